>>> hdl/tjq_pkg.sv
// Package with shared types and constants of the timed job queue.
package tjq_pkg;

  localparam int QueueDepth = 32;
  localparam int IdxW       = $clog2(QueueDepth);
  localparam int CntW       = $clog2(QueueDepth + 1);

  typedef enum logic [1:0] {
    ModeSchedule = 2'd0,
    ModeCancel   = 2'd1,
    ModeService  = 2'd2,
    ModeNone     = 2'd3
  } mode_e;

  typedef logic [IdxW-1:0] idx_t;
  typedef logic [CntW-1:0] cnt_t;

  typedef struct packed {
    logic [31:0] due;
    logic [31:0] group;
    logic [31:0] window;
    logic [15:0] command;
    logic [30:0] period;
  } job_t;

  // Serial comparison: a is at or after b.
  function automatic logic time_ge(input logic [31:0] a, input logic [31:0] b);
    logic [31:0] d;
    d = a - b;
    return ~d[31];
  endfunction

endpackage

>>> hdl/timed_job_queue_top.sv
// Top level of the timed job queue: sorted job memory and control sequencer.
//
// Usage: items enter on s_axis (mode, now, delay_ms, periodic, has_group,
// group_id, window_id, command_ref). Each item gives zero or more fired-job
// results and then one status result (tlast high) on m_axis.
// Jobs live in two memories (A and B) of QueueDepth entries with registered
// reads. An accepted schedule, a cancel or a service item copies the live
// entries from one memory to the other in a pass, dropping, firing or
// inserting jobs on the way, then swaps the roles of the two memories; a
// service item makes one more pass for each periodic job fired, to put it
// back. An item of mode none, or a schedule that is refused (queue full or
// zero command_ref), skips the pass.
// One item is worked on at a time; s_axis_tready is low until its status is
// in the output register. Results wait in the output register while
// m_axis_tready is low, and the sequencer holds until the register is free.
// Reset empties the queue (count to zero), sets the free group to -1 and
// the last group to zero; memory contents need no clearing.
module timed_job_queue_top (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          s_axis_tvalid,
  output logic          s_axis_tready,
  // mode[1:0], now[33:2], delay_ms[65:34], periodic[66], has_group[67],
  // group_id[99:68], window_id[131:100], command_ref[147:132], zero fill
  input  logic [151:0]  s_axis_tdata,
  output logic          m_axis_tvalid,
  input  logic          m_axis_tready,
  // result_kind[0], fired_window[32:1], fired_command[48:33],
  // result_group[80:49], next_wait_ms[112:81], overflow[113],
  // occupancy[119:114], zero fill
  output logic [127:0]  m_axis_tdata,
  output logic          m_axis_tlast
);

  typedef enum logic [2:0] {
    StIdle, StRead, StCheck, StFlush, StRein, StHead, StStat, StWait
  } state_e;

  state_e             state_q;
  logic               sel_q;             // memory holding the live queue
  tjq_pkg::cnt_t      count_q, wcnt_q;
  tjq_pkg::cnt_t      rd_q;
  logic [31:0]        free_q, last_q;
  logic [1:0]         mode_q;
  logic [31:0]        now_q, group_q;
  tjq_pkg::job_t      ins_q;            // job to insert during the pass
  logic               ins_v_q;
  logic               ovf_q;
  logic [31:0]        sgrp_q;
  // fired job list
  tjq_pkg::job_t      fired_mem [tjq_pkg::QueueDepth];
  tjq_pkg::cnt_t      nf_q, fi_q;
  tjq_pkg::job_t      fired_rd_q;

  tjq_pkg::job_t      mem_a [tjq_pkg::QueueDepth];
  tjq_pkg::job_t      mem_b [tjq_pkg::QueueDepth];
  tjq_pkg::job_t      rda_q, rdb_q, rdat;
  tjq_pkg::idx_t      raddr;
  logic               wen;
  tjq_pkg::idx_t      waddr;
  tjq_pkg::job_t      wdat;
  logic               fwen;
  tjq_pkg::idx_t      fraddr;

  logic               ovalid_q, olast_q;
  logic [127:0]       odata_q;

  always_ff @(posedge clk_i) begin
    rda_q <= mem_a[raddr];
    rdb_q <= mem_b[raddr];
    fired_rd_q <= fired_mem[fraddr];
    if (wen && sel_q) mem_a[waddr] <= wdat;
    if (wen && !sel_q) mem_b[waddr] <= wdat;
    if (fwen) fired_mem[nf_q[tjq_pkg::IdxW-1:0]] <= rdat;
  end
  assign rdat = sel_q ? rdb_q : rda_q;

  logic [151:0] d;
  assign d = s_axis_tdata;
  assign s_axis_tready = (state_q == StIdle);

  logic   keep, fire, ins_here;
  logic   out_free, out_set;
  assign out_free = !ovalid_q || m_axis_tready;
  assign raddr  = ((state_q == StHead) || (state_q == StStat)) ? '0 :
                  rd_q[tjq_pkg::IdxW-1:0];
  assign fraddr = fi_q[tjq_pkg::IdxW-1:0];
  assign out_set = out_free &&
                   ((state_q == StStat) || ((state_q == StCheck) && !ins_here && fire));

  // Per-entry decisions in StCheck, and the last insert in StFlush.
  always_comb begin
    fire = (mode_q == tjq_pkg::ModeService) && tjq_pkg::time_ge(now_q, rdat.due);
    keep = !fire && !((mode_q == tjq_pkg::ModeCancel) && rdat.group == group_q);
    ins_here = ins_v_q && !tjq_pkg::time_ge(ins_q.due, rdat.due);
    wen = 1'b0;
    waddr = wcnt_q[tjq_pkg::IdxW-1:0];
    wdat = rdat;
    fwen = 1'b0;
    unique case (state_q)
      StCheck: begin
        if (ins_here) begin
          wen = 1'b1;
          wdat = ins_q;
        end else begin
          wen = keep;
          fwen = fire && out_free;
        end
      end
      StFlush: begin
        wen = ins_v_q;
        wdat = ins_q;
      end
      default: ;
    endcase
  end

  logic [31:0] dly, ddiff;
  logic        sched_req, is_full, sched_ok, is_cancel, is_service;
  logic [31:0] ngrp, cgrp;
  assign dly = d[65] ? 32'd0 : d[65:34];
  assign ddiff = rdat.due - now_q;
  assign sched_req  = (d[1:0] == tjq_pkg::ModeSchedule) && (d[147:132] != '0);
  assign is_full    = (count_q == tjq_pkg::cnt_t'(tjq_pkg::QueueDepth));
  assign sched_ok   = sched_req && !is_full;
  assign is_cancel  = (d[1:0] == tjq_pkg::ModeCancel);
  assign is_service = (d[1:0] == tjq_pkg::ModeService);
  assign ngrp = d[67] ? d[99:68] : free_q;
  assign cgrp = d[67] ? d[99:68] : last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      sel_q <= 1'b0;
      count_q <= '0;
      wcnt_q <= '0;
      rd_q <= '0;
      free_q <= '1;
      last_q <= '0;
      ins_v_q <= 1'b0;
      nf_q <= '0;
      fi_q <= '0;
      ovalid_q <= 1'b0;
      olast_q <= 1'b0;
      mode_q <= '0;
      now_q <= '0;
      group_q <= '0;
      ins_q <= '0;
      ovf_q <= 1'b0;
      sgrp_q <= '0;
      odata_q <= '0;
    end else begin
      if (out_set) ovalid_q <= 1'b1;
      else if (m_axis_tready) ovalid_q <= 1'b0;
      unique case (state_q)
        StIdle: if (s_axis_tvalid) begin
          mode_q <= d[1:0];
          now_q <= d[33:2];
          nf_q <= '0;
          fi_q <= '0;
          rd_q <= '0;
          wcnt_q <= '0;
          group_q <= cgrp;
          ovf_q <= sched_req && is_full;
          sgrp_q <= sched_req ? ngrp : (is_cancel ? cgrp : '0);
          ins_v_q <= sched_ok;
          state_q <= (sched_ok || is_cancel || is_service) ? StRead : StHead;
          if (sched_ok) begin
            if (!d[67]) free_q <= (free_q == 32'h8000_0000) ? '1 : free_q - 32'd1;
            last_q <= ngrp;
            ins_q.due <= d[33:2] + dly;
            ins_q.group <= ngrp;
            ins_q.window <= d[131:100];
            ins_q.command <= d[147:132];
            ins_q.period <= d[66] ? dly[30:0] : '0;
          end
        end
        StRead: begin
          if (rd_q == count_q) state_q <= StFlush;
          else state_q <= StCheck;
        end
        StCheck: begin
          if (ins_here) begin
            ins_v_q <= 1'b0;
            wcnt_q <= wcnt_q + tjq_pkg::cnt_t'(1);
            state_q <= StCheck;
          end else if (fire) begin
            if (out_free) begin
              olast_q <= 1'b0;
              odata_q <= {8'd0, 6'd0, 1'b0, 32'd0, rdat.group, rdat.command,
                          rdat.window, 1'b0};
              nf_q <= nf_q + tjq_pkg::cnt_t'(1);
              rd_q <= rd_q + tjq_pkg::cnt_t'(1);
              state_q <= StRead;
            end
          end else begin
            if (keep) wcnt_q <= wcnt_q + tjq_pkg::cnt_t'(1);
            rd_q <= rd_q + tjq_pkg::cnt_t'(1);
            state_q <= StRead;
          end
        end
        StFlush: begin
          count_q <= wcnt_q + tjq_pkg::cnt_t'(ins_v_q);
          ins_v_q <= 1'b0;
          sel_q <= !sel_q;
          state_q <= StRein;
        end
        StRein: begin
          if (mode_q == tjq_pkg::ModeService && fi_q < nf_q) begin
            fi_q <= fi_q + tjq_pkg::cnt_t'(1);
            state_q <= StWait;
          end else state_q <= StHead;
        end
        StWait: begin
          if (fired_rd_q.period != '0) begin
            ins_v_q <= 1'b1;
            ins_q.due <= now_q + {1'b0, fired_rd_q.period};
            ins_q.group <= fired_rd_q.group;
            ins_q.window <= fired_rd_q.window;
            ins_q.command <= fired_rd_q.command;
            ins_q.period <= fired_rd_q.period;
            rd_q <= '0;
            wcnt_q <= '0;
            state_q <= StRead;
          end else state_q <= StRein;
        end
        StHead: state_q <= StStat;
        StStat: if (out_free) begin
          olast_q <= 1'b1;
          odata_q <= {8'd0, count_q[5:0], ovf_q,
                      (count_q == '0) ? 32'hFFFF_FFFF :
                      tjq_pkg::time_ge(now_q, rdat.due) ? 32'd0 :
                      ddiff[31] ? 32'h7FFF_FFFF : ddiff,
                      sgrp_q, 16'd0, 32'd0, 1'b1};
          state_q <= StIdle;
        end
        default: state_q <= StIdle;
      endcase
    end
  end

  assign m_axis_tvalid = ovalid_q;
  assign m_axis_tdata  = odata_q;
  assign m_axis_tlast  = olast_q;

endmodule

>>> hdl/tjq_checker.sv
// Port checker for the timed job queue, bound to the top level.
module tjq_checker (
  input logic         clk_i,
  input logic         rst_ni,
  input logic         s_axis_tvalid,
  input logic         s_axis_tready,
  input logic         m_axis_tvalid,
  input logic         m_axis_tready,
  input logic [127:0] m_axis_tdata,
  input logic         m_axis_tlast
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("output item changed while stalled");

  a_kind_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[0] == m_axis_tlast)
    else $error("result kind and tlast disagree");

  a_fired_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tlast |-> m_axis_tdata[119:81] == '0)
    else $error("fired item carries status fields");

  a_occ_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tlast |-> m_axis_tdata[119:114] <= 6'd32)
    else $error("occupancy out of range");

endmodule

bind timed_job_queue_top tjq_checker u_tjq_checker (.*);
